FILE: rtl/core/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int COUNT_W    = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  ASCII_POINT = 8'h2E;
   localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ   = 4'd3;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               fraction_mode;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_type;

endpackage

FILE: rtl/core/b2da_dabble.sv
// Iterative shift-and-add-3 binary to BCD converter, one input bit per cycle.
module b2da_dabble (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [b2da_pkg::VALUE_W-1:0] value,
   output logic                    done,
   output b2da_pkg::bcd_type       digits
);
   import b2da_pkg::*;

   logic                  busy_ff, busy_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [VALUE_W-1:0]    bin_ff, bin_in;
   bcd_type               bcd_ff, bcd_in;
   bcd_type               adj;

   // Each digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= DIGIT_FIVE) ? bcd_ff[i] + DIGIT_ADJ : bcd_ff[i];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      done     = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         bin_in   = value;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bin_in   = {bin_ff[VALUE_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         bcd_in[0] = {adj[0][DIGIT_W-2:0], bin_ff[VALUE_W-1]};
         for (int i = 1; i < NUM_DIGITS; i++) begin
            bcd_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
         end
         if (count_ff == COUNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digits = bcd_ff;

endmodule

FILE: rtl/core/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
//
// An item on the req_ channel carries a 32-bit unsigned value and a mode bit.
// The block answers with one rsp_ item per ASCII character, most significant
// digit first, with leading zeros dropped; last marks the final character.
// In whole mode the value is printed. In fraction mode the value counts
// hundredths: the integer part, then '.', then exactly two fraction digits.
// A zero integer part prints as a single '0'.
// The value is turned into ten BCD digits by a shift-and-add-3 unit that
// takes one input bit per cycle. A short scan then skips leading zero digits
// at one digit per cycle, and the characters leave one per cycle through the
// output register while rsp_stall is low. The block takes no new item until
// the current one is done: req_stall is high from acceptance until the last
// character has been loaded into the output register.
// When the receiver raises rsp_stall, the current character holds in the
// output register and the sequencer waits. Synchronous reset returns the
// sequencer to idle and empties the output register.
module binary_to_decimal_ascii_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b2da_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b2da_pkg::rsp_type rsp_data
);
   import b2da_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      CONVERT,
      SKIP,
      DIGITS,
      POINT,
      TENTHS,
      HUNDREDTHS
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               frac_ff, frac_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               conv_start;
   logic               conv_done;
   bcd_type            digits;
   logic [IDX_W-1:0]   min_idx;
   logic               slot_free;

   b2da_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_data.value),
      .done   (conv_done),
      .digits (digits)
   );

   // In fraction mode the two lowest BCD digits are the fraction digits, so the
   // integer part always keeps at least digit two.
   assign min_idx   = frac_ff ? IDX_W'(2) : '0;
   // The output register can take a new character when empty or being taken.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      conv_start   = 1'b0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               conv_start = 1'b1;
               frac_in    = req_data.fraction_mode;
               state_in   = CONVERT;
            end
         end
         CONVERT: begin
            if (conv_done) begin
               idx_in   = IDX_W'(NUM_DIGITS - 1);
               state_in = SKIP;
            end
         end
         SKIP: begin
            // Drop leading zero digits one per cycle.
            if (digits[idx_ff] == '0 && idx_ff != min_idx) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = DIGITS;
            end
         end
         DIGITS: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = ASCII_ZERO + CHAR_W'(digits[idx_ff]);
               rsp_data_in.last      = !frac_ff && idx_ff == '0;
               if (idx_ff == min_idx) begin
                  state_in = frac_ff ? POINT : IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         POINT: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = ASCII_POINT;
               rsp_data_in.last      = 1'b0;
               state_in              = TENTHS;
            end
         end
         TENTHS: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = ASCII_ZERO + CHAR_W'(digits[1]);
               rsp_data_in.last      = 1'b0;
               state_in              = HUNDREDTHS;
            end
         end
         HUNDREDTHS: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = ASCII_ZERO + CHAR_W'(digits[0]);
               rsp_data_in.last      = 1'b1;
               state_in              = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
